### src/u16u8_pkg.sv
// Shared types, constants and the code-unit encoder function of the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

  localparam int unsigned MAX_BYTES = 6;
  localparam int unsigned CNT_W     = 3;

  // Surrogate ranges by their top six bits
  localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  typedef logic [7:0] octet_t;

  // Encoding of one BMP value: up to three bytes, lowest index goes out first
  typedef struct packed {
    octet_t [2:0] b;
    logic   [1:0] len;
  } bmp_enc_t;

  // All bytes caused by one input item
  typedef struct packed {
    octet_t [MAX_BYTES-1:0] bytes;
    logic   [CNT_W-1:0]     cnt;
    logic                   fin;
  } run_t;

  function automatic bmp_enc_t enc_bmp(input logic [15:0] u);
    bmp_enc_t r;
    r.b   = '0;
    r.len = 2'd0;
    if (u[15:7] == 9'd0) begin
      r.b[0] = u[7:0];
      r.len  = 2'd1;
    end else if (u[15:11] == 5'd0) begin
      r.b[0] = {LEAD2_TAG, u[10:6]};
      r.b[1] = {CONT_TAG, u[5:0]};
      r.len  = 2'd2;
    end else begin
      r.b[0] = {LEAD3_TAG, u[15:12]};
      r.b[1] = {CONT_TAG, u[11:6]};
      r.b[2] = {CONT_TAG, u[5:0]};
      r.len  = 2'd3;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/u16u8_enc.sv
// Combinational encoder: one code unit plus the held surrogate into a run of UTF-8 bytes.
`default_nettype none
module u16u8_enc (
  input  wire logic [15:0]     code_unit,
  input  wire logic            final_unit,
  input  wire logic            held_valid,
  input  wire logic [9:0]      held_bits,
  output u16u8_pkg::run_t      run,
  output logic                 hold_nxt,
  output logic [9:0]           hold_bits_nxt
);

  logic                  is_high;
  logic                  is_low;
  logic [20:0]           cp;
  u16u8_pkg::bmp_enc_t   enc_held;
  u16u8_pkg::bmp_enc_t   enc_unit;
  logic [1:0]            len_unit;

  assign is_high = (code_unit[15:10] == u16u8_pkg::HIGH_SUR_TAG);
  assign is_low  = (code_unit[15:10] == u16u8_pkg::LOW_SUR_TAG);
  assign cp      = u16u8_pkg::SUPP_BASE + {1'b0, held_bits, code_unit[9:0]};

  assign enc_held = u16u8_pkg::enc_bmp({u16u8_pkg::HIGH_SUR_TAG, held_bits});
  assign enc_unit = u16u8_pkg::enc_bmp(code_unit);

  assign hold_bits_nxt = code_unit[9:0];

  always_comb begin
    run      = '0;
    run.fin  = final_unit;
    hold_nxt = 1'b0;
    len_unit = 2'd0;
    if (held_valid && is_low) begin
      run.bytes[0] = {u16u8_pkg::LEAD4_TAG, cp[20:18]};
      run.bytes[1] = {u16u8_pkg::CONT_TAG, cp[17:12]};
      run.bytes[2] = {u16u8_pkg::CONT_TAG, cp[11:6]};
      run.bytes[3] = {u16u8_pkg::CONT_TAG, cp[5:0]};
      run.cnt      = u16u8_pkg::CNT_W'(4);
    end else begin
      // Hold a new high surrogate unless it ends the text
      hold_nxt = is_high && !final_unit;
      len_unit = hold_nxt ? 2'd0 : enc_unit.len;
      if (held_valid) begin
        // Flush the unpaired held surrogate first
        run.bytes[0] = enc_held.b[0];
        run.bytes[1] = enc_held.b[1];
        run.bytes[2] = enc_held.b[2];
        run.bytes[3] = enc_unit.b[0];
        run.bytes[4] = enc_unit.b[1];
        run.bytes[5] = enc_unit.b[2];
        run.cnt      = u16u8_pkg::CNT_W'(3) + u16u8_pkg::CNT_W'(len_unit);
      end else begin
        run.bytes[0] = enc_unit.b[0];
        run.bytes[1] = enc_unit.b[1];
        run.bytes[2] = enc_unit.b[2];
        run.cnt      = u16u8_pkg::CNT_W'(len_unit);
      end
    end
  end

endmodule
`default_nettype wire

### src/u16u8_ser.sv
// Run buffer and output register: drains one UTF-8 byte per unstalled cycle to the output.
`default_nettype none
module u16u8_ser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            ld_en,
  input  wire u16u8_pkg::run_t ld_run,
  output logic                 ld_ready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_tdata,   // [7:0] out_byte
  output logic                 out_tlast,   // run_last
  output logic                 out_tuser    // [0] text_end
);

  u16u8_pkg::octet_t [u16u8_pkg::MAX_BYTES-1:0] bytes_r;
  logic [u16u8_pkg::CNT_W-1:0] cnt_r;
  logic [u16u8_pkg::CNT_W-1:0] idx_r;
  logic                        fin_r;
  logic                        busy_r;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic                        out_end_r;

  logic pop;
  logic last_pop;
  logic load;

  assign pop      = busy_r && (!out_valid_r || out_tready);
  assign last_pop = pop && (idx_r == cnt_r - u16u8_pkg::CNT_W'(1));
  assign ld_ready = !busy_r || last_pop;
  assign load     = ld_en && (ld_run.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (last_pop) begin
      busy_r <= 1'b0;
    end else if (pop) begin
      idx_r <= idx_r + u16u8_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= ld_run.bytes;
      cnt_r   <= ld_run.cnt;
      fin_r   <= ld_run.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= bytes_r[idx_r];
      out_last_r <= last_pop;
      out_end_r  <= last_pop && fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0) && (idx_r < cnt_r))
    else $error("run index beyond byte count");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= u16u8_pkg::CNT_W'(u16u8_pkg::MAX_BYTES)))
    else $error("run longer than six bytes");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ld_ready)
    else $error("run loaded over an undrained run");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_last_r)
    else $error("text end marked on a byte that does not end its run");

endmodule
`default_nettype wire

### src/utf16_to_utf8_stream.sv
// Top level of the UTF-16 to UTF-8 transcoder: input register, held surrogate, encoder, drain.
//
//  channel | dir | tdata            | tlast      | tuser
//  in_     | in  | [15:0] code_unit | final_unit | -
//  out_    | out | [7:0]  out_byte  | run_last   | [0] text_end
//
// One byte leaves per cycle while out_tready allows; an item yields 0 to 6 bytes
// (3 at most for a lone BMP unit, 4 for a pair, 3 to 6 on a flush).
// The first byte passes the input register, the run buffer and the output register.
// The next item is encoded while the last byte of the current run is leaving.
// Reset (rst_n low, synchronous) drops all items in flight and the held surrogate.
// Back-pressure on out_tready stalls the drain and then in_tready.
`default_nettype none
module utf16_to_utf8_stream (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] code_unit
  input  wire logic        in_tlast,    // final_unit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] out_byte
  output logic             out_tlast,   // run_last
  output logic             out_tuser    // [0] text_end
);

  logic            in_valid_r;
  logic [15:0]     unit_r;
  logic            fin_r;
  logic            held_r;
  logic [9:0]      held_bits_r;

  u16u8_pkg::run_t run;
  logic            hold_nxt;
  logic [9:0]      hold_bits_nxt;
  logic            ld_ready;
  logic            consume;

  // An item that only becomes held needs no room in the run buffer
  assign consume   = in_valid_r && (ld_ready || (run.cnt == '0));
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      unit_r <= in_tdata;
      fin_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      held_bits_r <= '0;
    end else if (consume) begin
      held_r      <= hold_nxt;
      held_bits_r <= hold_nxt ? hold_bits_nxt : 10'd0;
    end
  end

  u16u8_enc u_enc (
    .code_unit     (unit_r),
    .final_unit    (fin_r),
    .held_valid    (held_r),
    .held_bits     (held_bits_r),
    .run           (run),
    .hold_nxt      (hold_nxt),
    .hold_bits_nxt (hold_bits_nxt)
  );

  u16u8_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_en      (consume),
    .ld_run     (run),
    .ld_ready   (ld_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
